// ----- hdl/assert_macros.svh -----
// Assertion macros of the stiction breakaway compensator, used by the top level.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SBC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbc assertion failed");

// Next-cycle implication, checked outside reset
`define SBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbc assertion failed");

`endif

// ----- hdl/sbc_pkg.sv -----
// Types and constants of the stiction breakaway compensator.
// Used by sbc_regs, sbc_front, sbc_core and the top level; no dependencies.
package sbc_pkg;

    localparam int ADDR_W    = 5;
    localparam int ALPHA_W   = 17;
    localparam int ANGLE_W   = 20;
    localparam int LEVEL_W   = 19;
    localparam int DIN_W     = 136;
    localparam int DOUT_W    = 32;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 19'd500000;
    localparam logic [23:0]        REF_VEL_MIN = 24'd100;

    // Register indexes
    localparam logic [2:0] REG_POS_DB    = 3'd0;
    localparam logic [2:0] REG_VEL_DB    = 3'd1;
    localparam logic [2:0] REG_STAT_VEL  = 3'd2;
    localparam logic [2:0] REG_ROLL_VEL  = 3'd3;
    localparam logic [2:0] REG_ACCEL_THR = 3'd4;
    localparam logic [2:0] REG_BRK_TIME  = 3'd5;
    localparam logic [2:0] REG_ROLL_LVL  = 3'd6;
    localparam logic [2:0] REG_BRK_LVL   = 3'd7;

    // Mode codes
    localparam logic [2:0] MODE_HOLD     = 3'd0;
    localparam logic [2:0] MODE_BRK_POS  = 3'd1;
    localparam logic [2:0] MODE_BRK_NEG  = 3'd2;
    localparam logic [2:0] MODE_ROLL_POS = 3'd3;
    localparam logic [2:0] MODE_ROLL_NEG = 3'd4;

    // Direction codes, two's complement
    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_POS  = 2'b01;
    localparam logic [1:0] DIR_NEG  = 2'b11;

    typedef struct packed {
        logic [22:0]        pos_db;
        logic [22:0]        vel_db;
        logic [22:0]        stat_vel;
        logic [22:0]        roll_vel;
        logic [23:0]        accel_thr;
        logic [23:0]        brk_time;
        logic [LEVEL_W-1:0] roll_lvl;
        logic [LEVEL_W-1:0] brk_lvl;
    } t_cfg;

    // Per-item data handed from the front stage to the core
    typedef struct packed {
        logic               enable;
        logic [31:0]        sample_time;
        logic               in_deadband;
        logic [1:0]         req_dir;
        logic               roll_hi;
        logic               stat_lo;
        logic [ALPHA_W-1:0] alpha;
    } t_stage_a;

    typedef struct packed {
        logic               in_deadband;
        logic [1:0]         direction;
        logic [2:0]         mode;
        logic [ANGLE_W-1:0] angle;
    } t_result;

endpackage

// ----- hdl/sbc_regs.sv -----
// APB configuration registers of the stiction breakaway compensator.
// Depends on sbc_pkg.
module sbc_regs
    import sbc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg               r_cfg;
    logic               w_wr;
    logic [LEVEL_W-1:0] w_lvl;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    // levels saturate on write
    assign w_lvl  = (pwdata[LEVEL_W-1:0] > LEVEL_MAX) ? LEVEL_MAX : pwdata[LEVEL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_db    <= 23'd1000;
            r_cfg.vel_db    <= 23'd2000;
            r_cfg.stat_vel  <= 23'd1000;
            r_cfg.roll_vel  <= 23'd5000;
            r_cfg.accel_thr <= 24'd50000;
            r_cfg.brk_time  <= 24'd8000;
            r_cfg.roll_lvl  <= '0;
            r_cfg.brk_lvl   <= '0;
        end else if (w_wr) begin
            case (paddr[4:2])
                REG_POS_DB:    r_cfg.pos_db    <= pwdata[22:0];
                REG_VEL_DB:    r_cfg.vel_db    <= pwdata[22:0];
                REG_STAT_VEL:  r_cfg.stat_vel  <= pwdata[22:0];
                REG_ROLL_VEL:  r_cfg.roll_vel  <= pwdata[22:0];
                REG_ACCEL_THR: r_cfg.accel_thr <= pwdata[23:0];
                REG_BRK_TIME:  r_cfg.brk_time  <= pwdata[23:0];
                REG_ROLL_LVL:  r_cfg.roll_lvl  <= w_lvl;
                REG_BRK_LVL:   r_cfg.brk_lvl   <= w_lvl;
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    // read back
    always_comb begin
        case (paddr[4:2])
            REG_POS_DB:    prdata = {9'd0, r_cfg.pos_db};
            REG_VEL_DB:    prdata = {9'd0, r_cfg.vel_db};
            REG_STAT_VEL:  prdata = {9'd0, r_cfg.stat_vel};
            REG_ROLL_VEL:  prdata = {9'd0, r_cfg.roll_vel};
            REG_ACCEL_THR: prdata = {8'd0, r_cfg.accel_thr};
            REG_BRK_TIME:  prdata = {8'd0, r_cfg.brk_time};
            REG_ROLL_LVL:  prdata = {13'd0, r_cfg.roll_lvl};
            REG_BRK_LVL:   prdata = {13'd0, r_cfg.brk_lvl};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/sbc_front.sv -----
// Front stage: input register, time step and blend factor, deadband and
// direction request. Depends on sbc_pkg.
module sbc_front
    import sbc_pkg::*;
#(
    parameter int UNITS_PER_PERIOD = 16,
    parameter int BLEND_UNITS      = 64,
    parameter int BRAKE_DECEL      = 2000000
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load_in,
    input  logic             i_load_a,
    input  logic [DIN_W-1:0] i_data,
    input  t_cfg             i_cfg,
    output t_stage_a         o_stage_a
);

    localparam int BLEND_T = (UNITS_PER_PERIOD > BLEND_UNITS) ? UNITS_PER_PERIOD : BLEND_UNITS;
    localparam longint DEN = 64'(8 * BLEND_T);
    localparam int DT_MAX  = 5 * UNITS_PER_PERIOD;
    localparam int DT_W    = $clog2(DT_MAX + 1);
    localparam logic [24:0] BRAKE2 = 25'(2 * BRAKE_DECEL);

    // floor(x / k) for the series terms, small constant divisors only
    function automatic logic [63:0] div_k(input logic [63:0] x, input int k);
        logic [63:0] q;
        case (k)
            2:       q = x / 2;
            3:       q = x / 3;
            4:       q = x / 4;
            5:       q = x / 5;
            6:       q = x / 6;
            7:       q = x / 7;
            8:       q = x / 8;
            9:       q = x / 9;
            10:      q = x / 10;
            11:      q = x / 11;
            12:      q = x / 12;
            13:      q = x / 13;
            14:      q = x / 14;
            15:      q = x / 15;
            16:      q = x / 16;
            default: q = x;
        endcase
        return q;
    endfunction

    // Q16 blend factor 1 - exp(-dt/B), worked out at elaboration
    function automatic logic [ALPHA_W-1:0] alpha_of(input int dt);
        logic [63:0] z;
        logic [63:0] term;
        logic [63:0] p;
        longint      sum;
        z    = ((64'(dt) << 30) + DEN / 2) / DEN;
        term = 64'd1 << 30;
        sum  = 64'sd1 << 30;
        for (int k = 1; k <= 16; k++) begin
            term = div_k((term * z + (64'd1 << 29)) >> 30, k);
            if (k % 2 == 1) sum = sum - longint'(term);
            else            sum = sum + longint'(term);
        end
        if (sum < 0)                 sum = 0;
        if (sum > (64'sd1 << 30))    sum = 64'sd1 << 30;
        p = 64'(sum);
        for (int k = 0; k < 3; k++) p = (p * p + (64'd1 << 29)) >> 30;
        return ALPHA_W'(64'd65536 - ((p + 64'd8192) >> 14));
    endfunction

    logic [DIN_W-1:0]   r_in;
    logic [31:0]        r_last_time;
    logic               r_last_valid;
    t_stage_a           r_a;
    t_stage_a           n_a;

    logic [ALPHA_W-1:0] w_alpha_tab [0:DT_MAX];

    logic [31:0]        w_now;
    logic               w_en;
    logic signed [23:0] w_e;
    logic signed [23:0] w_v;
    logic signed [24:0] w_u;
    logic signed [23:0] w_r;
    logic [23:0]        w_ae;
    logic [23:0]        w_av;
    logic [24:0]        w_au;
    logic [23:0]        w_ar;
    logic [31:0]        w_diff;
    logic [DT_W-1:0]    w_dt;
    logic [47:0]        w_vv;
    logic [48:0]        w_lim;
    logic               w_outside;
    logic               w_toward;
    logic [1:0]         w_dir_e;

    // blend factor table, one constant per clamped time step
    for (genvar g = 0; g <= DT_MAX; g++) begin : g_alpha
        assign w_alpha_tab[g] = alpha_of(g);
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (i_load_in) r_in <= i_data;
    end

    // unpack tdata
    assign w_now = r_in[31:0];
    assign w_en  = r_in[32];
    assign w_e   = r_in[56:33];
    assign w_v   = r_in[80:57];
    assign w_u   = r_in[105:81];
    assign w_r   = r_in[129:106];

    assign w_ae = w_e[23] ? 24'(-w_e) : 24'(w_e);
    assign w_av = w_v[23] ? 24'(-w_v) : 24'(w_v);
    assign w_au = w_u[24] ? 25'(-w_u) : 25'(w_u);
    assign w_ar = w_r[23] ? 24'(-w_r) : 24'(w_r);

    // time step since the previous active sample, clamped
    assign w_diff = w_now - r_last_time;
    always_comb begin
        if (!r_last_valid)                w_dt = DT_W'(UNITS_PER_PERIOD);
        else if (w_diff[31])              w_dt = '0;
        else if (w_diff > 32'(DT_MAX))    w_dt = DT_W'(DT_MAX);
        else                              w_dt = w_diff[DT_W-1:0];
    end

    // braking check: v^2 against 2*decel*|e|
    assign w_vv  = w_av * w_av;
    assign w_lim = BRAKE2 * w_ae;

    assign w_outside = w_ae >= {1'b0, i_cfg.pos_db};
    assign w_toward  = (!w_e[23] && (w_e != '0) && !w_v[23] && (w_v != '0)) ||
                       (w_e[23] && w_v[23]);
    assign w_dir_e   = (!w_e[23] && (w_e != '0)) ? DIR_POS : DIR_NEG;

    // direction request and per-item flags
    always_comb begin
        n_a             = '0;
        n_a.enable      = w_en;
        n_a.sample_time = w_now;
        n_a.alpha       = w_alpha_tab[w_dt];
        n_a.in_deadband = !w_outside && (w_av < {1'b0, i_cfg.vel_db});
        n_a.roll_hi     = w_av >= {1'b0, i_cfg.roll_vel};
        n_a.stat_lo     = w_av <= {1'b0, i_cfg.stat_vel};
        if (w_outside && (w_av > {1'b0, i_cfg.vel_db}) &&
            (!w_toward || ({1'b0, w_vv} >= w_lim))) begin
            n_a.req_dir = (!w_v[23] && (w_v != '0)) ? DIR_NEG : DIR_POS;
        end else if (w_ar >= REF_VEL_MIN) begin
            n_a.req_dir = (!w_r[23] && (w_r != '0)) ? DIR_POS : DIR_NEG;
        end else if (w_outside && (w_av <= {1'b0, i_cfg.stat_vel})) begin
            n_a.req_dir = w_dir_e;
        end else if (w_au >= {1'b0, i_cfg.accel_thr}) begin
            n_a.req_dir = (!w_u[24] && (w_u != '0)) ? DIR_POS : DIR_NEG;
        end else if (w_outside) begin
            n_a.req_dir = w_dir_e;
        end else begin
            n_a.req_dir = DIR_NONE;
        end
    end

    // stage register and last sample time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_valid <= 1'b0;
            r_last_time  <= '0;
        end else if (i_load_a) begin
            r_last_valid <= w_en;
            r_last_time  <= w_en ? w_now : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_a) r_a <= n_a;
    end

    assign o_stage_a = r_a;

endmodule

// ----- hdl/sbc_core.sv -----
// Core stage: mode and breakaway state, target level, first-order blend of
// the angle, result register. Depends on sbc_pkg.
module sbc_core
    import sbc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load_out,
    input  t_stage_a i_stage_a,
    input  t_cfg     i_cfg,
    output t_result  o_result
);

    logic [2:0]                r_mode;
    logic [1:0]                r_dir;
    logic [ANGLE_W-1:0]        r_angle;
    logic [31:0]               r_brk_start;
    logic                      r_brk_valid;
    logic [1:0]                r_brk_dir;
    logic                      r_brk_exp;
    t_result                   r_out;

    logic [2:0]                n_mode;
    logic [1:0]                n_dir;
    logic [ANGLE_W-1:0]        n_angle;
    logic [31:0]               n_brk_start;
    logic                      n_brk_valid;
    logic [1:0]                n_brk_dir;
    logic                      n_brk_exp;

    logic                      w_rolling;
    logic [31:0]               w_elapsed;
    logic signed [ANGLE_W-1:0] w_target;
    logic signed [ANGLE_W:0]   w_d;
    logic [ANGLE_W-1:0]        w_dmag;
    logic [ALPHA_W+ANGLE_W-1:0] w_prod;
    logic [ALPHA_W+ANGLE_W-1:0] w_prod_rnd;
    logic [ANGLE_W-1:0]        w_step;

    // signed level for the current direction
    function automatic logic [ANGLE_W-1:0] signed_level(input logic [1:0] dir,
                                                        input logic [LEVEL_W-1:0] lvl);
        logic [ANGLE_W-1:0] l;
        l = {1'b0, lvl};
        return (dir == DIR_POS) ? l : ANGLE_W'(-l);
    endfunction

    // mode and breakaway state update
    always_comb begin
        n_mode      = r_mode;
        n_dir       = r_dir;
        n_brk_start = r_brk_start;
        n_brk_valid = r_brk_valid;
        n_brk_dir   = r_brk_dir;
        n_brk_exp   = r_brk_exp;
        w_target    = '0;
        w_rolling   = (r_mode == MODE_ROLL_POS) || (r_mode == MODE_ROLL_NEG);
        w_elapsed   = '0;
        if (i_stage_a.in_deadband) begin
            n_mode      = MODE_HOLD;
            n_dir       = DIR_NONE;
            n_brk_valid = 1'b0;
            n_brk_dir   = DIR_NONE;
            n_brk_exp   = 1'b0;
        end else begin
            if ((i_stage_a.req_dir != DIR_NONE) && (i_stage_a.req_dir != r_dir)) begin
                n_dir       = i_stage_a.req_dir;
                n_brk_valid = 1'b0;
                n_brk_dir   = i_stage_a.req_dir;
                n_brk_exp   = 1'b0;
            end
            // velocity hysteresis
            if (i_stage_a.roll_hi)      w_rolling = 1'b1;
            else if (i_stage_a.stat_lo) w_rolling = 1'b0;

            if (n_dir == DIR_NONE) begin
                n_mode = MODE_HOLD;
            end else if (w_rolling) begin
                n_mode   = (n_dir == DIR_POS) ? MODE_ROLL_POS : MODE_ROLL_NEG;
                w_target = signed_level(n_dir, i_cfg.roll_lvl);
            end else begin
                if (n_brk_dir != n_dir) begin
                    n_brk_dir   = n_dir;
                    n_brk_valid = 1'b0;
                    n_brk_exp   = 1'b0;
                end
                if (!n_brk_valid) begin
                    n_brk_start = i_stage_a.sample_time;
                    n_brk_valid = 1'b1;
                end
                // breakaway timer, wrapped difference read as signed
                w_elapsed = i_stage_a.sample_time - n_brk_start;
                if (!w_elapsed[31] && (w_elapsed >= {8'd0, i_cfg.brk_time})) begin
                    n_brk_exp = 1'b1;
                end else if (w_elapsed[31] && (i_cfg.brk_time == '0)) begin
                    n_brk_exp = 1'b1;
                end
                if (n_brk_exp) begin
                    n_mode   = (n_dir == DIR_POS) ? MODE_ROLL_POS : MODE_ROLL_NEG;
                    w_target = signed_level(n_dir, i_cfg.roll_lvl);
                end else begin
                    n_mode   = (n_dir == DIR_POS) ? MODE_BRK_POS : MODE_BRK_NEG;
                    w_target = signed_level(n_dir, i_cfg.brk_lvl);
                end
            end
        end
        // disabled sample clears everything
        if (!i_stage_a.enable) begin
            n_mode      = MODE_HOLD;
            n_dir       = DIR_NONE;
            n_brk_start = '0;
            n_brk_valid = 1'b0;
            n_brk_dir   = DIR_NONE;
            n_brk_exp   = 1'b0;
        end
    end

    // first-order blend toward the target, rounding half away from zero
    assign w_d        = {w_target[ANGLE_W-1], w_target} - {r_angle[ANGLE_W-1], r_angle};
    assign w_dmag     = w_d[ANGLE_W] ? ANGLE_W'(-w_d) : ANGLE_W'(w_d);
    assign w_prod     = i_stage_a.alpha * w_dmag;
    assign w_prod_rnd = w_prod + (ALPHA_W+ANGLE_W)'(32768);
    assign w_step     = w_prod_rnd[ANGLE_W+15:16];

    always_comb begin
        if (!i_stage_a.enable)  n_angle = '0;
        else if (w_d[ANGLE_W])  n_angle = r_angle - w_step;
        else                    n_angle = r_angle + w_step;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_HOLD;
            r_dir       <= DIR_NONE;
            r_angle     <= '0;
            r_brk_start <= '0;
            r_brk_valid <= 1'b0;
            r_brk_dir   <= DIR_NONE;
            r_brk_exp   <= 1'b0;
        end else if (i_load_out) begin
            r_mode      <= n_mode;
            r_dir       <= n_dir;
            r_angle     <= n_angle;
            r_brk_start <= n_brk_start;
            r_brk_valid <= n_brk_valid;
            r_brk_dir   <= n_brk_dir;
            r_brk_exp   <= n_brk_exp;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_load_out) begin
            r_out.angle       <= n_angle;
            r_out.mode        <= n_mode;
            r_out.direction   <= n_dir;
            r_out.in_deadband <= i_stage_a.enable & i_stage_a.in_deadband;
        end
    end

    assign o_result = r_out;

endmodule

// ----- hdl/stiction_breakaway_compensator.sv -----
// Top level of the stiction breakaway compensator: stream ports, pipeline
// control, APB registers. Depends on sbc_pkg, sbc_regs, sbc_front, sbc_core.
//
//   channel   direction  handshake                  payload
//   s_axis    in         i_s_axis_tvalid/o_..tready  sample (136-bit tdata)
//   m_axis    out        o_m_axis_tvalid/i_..tready  result (32-bit tdata)
//   apb       in         psel/penable/pready         8 registers at 4*i
//
// One item per cycle, sustained while m_axis does not stall. An input transfer
// passes the input register, the front stage and the result register to m_axis.
// The axis state (mode, timer, angle) closes its loop inside the core stage.
// Reset is synchronous; no memories, so no clearing pass. A stall on m_axis
// fills the three stages before s_axis tready drops.
module stiction_breakaway_compensator
    import sbc_pkg::*;
#(
    parameter int UNITS_PER_PERIOD = 16,
    parameter int BLEND_UNITS      = 64,
    parameter int BRAKE_DECEL      = 2000000
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // sample_time[31:0], enable[32], position_error[56:33], velocity[80:57],
    // requested_accel[105:81], reference_velocity[129:106], zeros[135:130]
    input  logic [DIN_W-1:0]  i_s_axis_tdata,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // compensation_angle[19:0], mode[22:20], direction[24:23],
    // in_deadband[25], zeros[31:26]
    output logic [DOUT_W-1:0] o_m_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    `include "assert_macros.svh"

    t_cfg     w_cfg;
    t_stage_a w_stage_a;
    t_result  w_result;

    logic r_in_v;
    logic r_a_v;
    logic r_out_v;
    logic w_out_rdy;
    logic w_a_rdy;
    logic w_load_in;
    logic w_load_a;
    logic w_load_out;

    sbc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sbc_front #(
        .UNITS_PER_PERIOD (UNITS_PER_PERIOD),
        .BLEND_UNITS      (BLEND_UNITS),
        .BRAKE_DECEL      (BRAKE_DECEL)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load_in (w_load_in),
        .i_load_a  (w_load_a),
        .i_data    (i_s_axis_tdata),
        .i_cfg     (w_cfg),
        .o_stage_a (w_stage_a)
    );

    sbc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load_out (w_load_out),
        .i_stage_a  (w_stage_a),
        .i_cfg      (w_cfg),
        .o_result   (w_result)
    );

    // pipeline control: a stage loads when empty or when it empties downstream
    assign w_out_rdy       = !r_out_v || i_m_axis_tready;
    assign w_load_out      = r_a_v && w_out_rdy;
    assign w_a_rdy         = !r_a_v || w_out_rdy;
    assign w_load_a        = r_in_v && w_a_rdy;
    assign o_s_axis_tready = !r_in_v || w_a_rdy;
    assign w_load_in       = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_a_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_load_in)      r_in_v <= 1'b1;
            else if (w_load_a)  r_in_v <= 1'b0;
            if (w_load_a)       r_a_v  <= 1'b1;
            else if (w_load_out) r_a_v <= 1'b0;
            if (w_load_out)     r_out_v <= 1'b1;
            else if (i_m_axis_tready) r_out_v <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {6'd0, w_result};

    // input side stalls only when every stage holds a transfer
    `SBC_ASSERT_IMPLY(a_stall_full, i_clk, i_rst_n, !o_s_axis_tready,
        r_in_v && r_a_v && r_out_v && !i_m_axis_tready)
    // deadband result is hold with no direction
    `SBC_ASSERT_IMPLY(a_deadband_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tdata[25],
        (o_m_axis_tdata[22:20] == MODE_HOLD) && (o_m_axis_tdata[24:23] == DIR_NONE))
    // positive modes go with a positive direction
    `SBC_ASSERT_IMPLY(a_mode_dir, i_clk, i_rst_n,
        o_m_axis_tvalid && ((o_m_axis_tdata[22:20] == MODE_BRK_POS) ||
                            (o_m_axis_tdata[22:20] == MODE_ROLL_POS)),
        o_m_axis_tdata[24:23] == DIR_POS)
    // a stage that loads holds a valid transfer next cycle
    `SBC_ASSERT_NEXT(a_load_keeps, i_clk, i_rst_n, w_load_a, r_a_v)

endmodule
